// ===== hdl/cesu_pkg.sv =====
// Shared constants, types and fixed-point helpers for the envelope stencil core.
// Depends on nothing; every other file in hdl/ imports it.
package cesu_pkg;

    localparam int ROW_CELLS = 1024;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(ROW_CELLS);
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] fix_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_REDUCED     = 3'd0,
        REG_INV_DX_SQUARED   = 3'd1,
        REG_ADVECT_COEF_IMAG = 3'd2,
        REG_DT_SQUARED       = 3'd3,
        REG_PREV_COEF_IMAG   = 3'd4,
        REG_SCALE_REAL       = 3'd5,
        REG_SCALE_IMAG       = 3'd6,
        REG_DISP_DELTA       = 3'd7
    } cfg_reg_t;

    // One in fixed point, the reset value of the real scale.
    localparam fix_t FIX_ONE = fix_t'(64'sd1 <<< FRAC_BITS);

    // Rounding offset added before the product is shifted down.
    localparam logic signed [64:0] MQ_HALF = 65'sd1 <<< (FRAC_BITS - 1);

    // Saturate a wide signed value to the 32-bit range.
    function automatic fix_t sat32(input logic signed [63:0] x);
        fix_t r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = fix_t'(x);
        end
        return r;
    endfunction

    // Fixed-point product, rounded half up and saturated.
    function automatic fix_t mq(input fix_t a, input fix_t b);
        logic signed [64:0] s;
        s = 65'(a) * 65'(b) + MQ_HALF;
        return sat32(64'(s >>> FRAC_BITS));
    endfunction

endpackage

// ===== hdl/cesu_if.sv =====
// Valid/ready channel interfaces for cells in and results out.
// Depends on cesu_pkg.
interface cesu_in_if;
    import cesu_pkg::*;

    logic valid;
    logic ready;
    fix_t cur_re;
    fix_t cur_im;
    fix_t prev_re;
    fix_t prev_im;
    fix_t chi;
    logic last_cell;

    modport source (output valid, cur_re, cur_im, prev_re, prev_im, chi, last_cell,
                    input ready);
    modport sink   (input valid, cur_re, cur_im, prev_re, prev_im, chi, last_cell,
                    output ready);
endinterface

interface cesu_out_if;
    import cesu_pkg::*;

    logic valid;
    logic ready;
    fix_t next_re;
    fix_t next_im;
    fix_t store_prev_re;
    fix_t store_prev_im;
    logic row_end;

    modport source (output valid, next_re, next_im, store_prev_re, store_prev_im, row_end,
                    input ready);
    modport sink   (input valid, next_re, next_im, store_prev_re, store_prev_im, row_end,
                    output ready);
endinterface

// ===== hdl/complex_envelope_stencil_update_core.sv =====
// Top level of the envelope stencil core: cell window, result sequencer and pipeline.
// Depends on cesu_pkg and the channel interfaces in cesu_if.sv.
//
// Usage:
// Cells of one row enter on cell_in, one item per cycle while cell_in.ready is high.
// The core keeps a window of the last five cells; when cell k is taken it issues the
// result for cell k-2. On the final cell of a row (last_cell set, or the
// ROW_CELLS-th cell) it also issues the remaining cells, so up to three results for
// that item; cell_in.ready then stays low while the sequencer hands them to the
// pipeline. Results leave on result_out in cell order, one per cycle at most.
// Path: the sequencer registers a taken cell and then issues its result into stage 0;
// stages 1 to 8 follow in order, and stage 8 holds the result in the output register.
// Each stage holds at most one 32x32 multiplier or one saturating add. The extra
// results of a final cell follow it in cell order.
// Throughput: one cell per cycle within a row while the receiver does not stall, set
// by the one-result-per-cycle sequencer.
// Configuration is written through cfg_we/cfg_idx/cfg_data while the core is idle.
// Reset restores the register defaults, returns the row position to zero and empties
// the pipeline; window contents are not cleared and are only read after being written.
// When the receiver stalls, every stage holds its item and cell_in.ready drops once
// the pipeline is full; nothing is lost or repeated.
module complex_envelope_stencil_update_core (
    input  logic                              clk,
    input  logic                              rst_n,
    cesu_in_if.sink                           cell_in,
    cesu_out_if.source                        result_out,
    input  logic                              cfg_we,
    input  logic [cesu_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [cesu_pkg::DATA_W-1:0]       cfg_data
);
    import cesu_pkg::*;

    localparam int NSTG = 9;
    localparam int KW   = IDX_W + 1;

    // Configuration registers.
    logic mode_reg;
    fix_t idx2_reg;
    fix_t adv_coef_reg;
    fix_t dt2_reg;
    fix_t pcoef_reg;
    fix_t sr_reg;
    fix_t si_reg;
    fix_t delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            idx2_reg     <= '0;
            adv_coef_reg <= '0;
            dt2_reg      <= '0;
            pcoef_reg    <= '0;
            sr_reg       <= FIX_ONE;
            si_reg       <= '0;
            delta_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_MODE_REDUCED:     mode_reg     <= cfg_data[0];
                REG_INV_DX_SQUARED:   idx2_reg     <= fix_t'(cfg_data);
                REG_ADVECT_COEF_IMAG: adv_coef_reg <= fix_t'(cfg_data);
                REG_DT_SQUARED:       dt2_reg      <= fix_t'(cfg_data);
                REG_PREV_COEF_IMAG:   pcoef_reg    <= fix_t'(cfg_data);
                REG_SCALE_REAL:       sr_reg       <= fix_t'(cfg_data);
                REG_SCALE_IMAG:       si_reg       <= fix_t'(cfg_data);
                REG_DISP_DELTA:       delta_reg    <= fix_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // Handshake and stage advance chain.
    logic            in_acc;
    logic            issue;
    logic            row_last;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] adv;

    logic             job_busy_reg;
    logic [1:0]       job_o_reg;
    logic [1:0]       job_lo_reg;
    logic [IDX_W-1:0] job_k_reg;
    logic             job_last_reg;
    logic [IDX_W-1:0] k_reg;

    assign issue         = job_busy_reg && adv[0];
    assign cell_in.ready = !job_busy_reg || (issue && (job_o_reg == job_lo_reg));
    assign in_acc        = cell_in.valid && cell_in.ready;
    assign row_last      = cell_in.last_cell || (k_reg == IDX_W'(ROW_CELLS - 1));

    always_comb
    begin
        adv[NSTG-1] = !v_reg[NSTG-1] || result_out.ready;
        for (int s = NSTG - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    // Cell window and delay lines, shifted on every accepted item.
    fix_t win_re_reg [5];
    fix_t win_im_reg [5];
    fix_t pd_re_reg  [3];
    fix_t pd_im_reg  [3];
    fix_t chi_reg    [3];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 4; i > 0; i--)
            begin
                win_re_reg[i] <= win_re_reg[i-1];
                win_im_reg[i] <= win_im_reg[i-1];
            end
            for (int i = 2; i > 0; i--)
            begin
                pd_re_reg[i] <= pd_re_reg[i-1];
                pd_im_reg[i] <= pd_im_reg[i-1];
                chi_reg[i]   <= chi_reg[i-1];
            end
            win_re_reg[0] <= cell_in.cur_re;
            win_im_reg[0] <= cell_in.cur_im;
            pd_re_reg[0]  <= cell_in.prev_re;
            pd_im_reg[0]  <= cell_in.prev_im;
            chi_reg[0]    <= cell_in.chi;
        end
    end

    // Row position and result sequencer: a result per cycle unless stalled, oldest first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            job_busy_reg <= 1'b0;
            job_o_reg    <= '0;
            job_lo_reg   <= '0;
            job_k_reg    <= '0;
            job_last_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            k_reg        <= row_last ? '0 : k_reg + IDX_W'(1);
            job_busy_reg <= row_last || (k_reg >= IDX_W'(2));
            job_o_reg    <= (k_reg >= IDX_W'(2)) ? 2'd2 : k_reg[1:0];
            job_lo_reg   <= row_last ? 2'd0 : 2'd2;
            job_k_reg    <= k_reg;
            job_last_reg <= row_last;
        end
        else if (issue)
        begin
            if (job_o_reg == job_lo_reg)
            begin
                job_busy_reg <= 1'b0;
            end
            else
            begin
                job_o_reg <= job_o_reg - 2'd1;
            end
        end
    end

    // Neighborhood of the issued cell, centered at index 2; cells outside the window
    // read as zero and are never used by an interior result.
    fix_t       nb [2][5];
    logic [1:0] m_sel;
    logic       job_inter;
    logic       job_end;

    always_comb
    begin
        int p;
        for (int j = 0; j < 5; j++)
        begin
            p = int'(job_o_reg) - 2 + j;
            if (p >= 0 && p <= 4)
            begin
                nb[0][j] = win_re_reg[p[2:0]];
                nb[1][j] = win_im_reg[p[2:0]];
            end
            else
            begin
                nb[0][j] = '0;
                nb[1][j] = '0;
            end
        end
    end

    assign m_sel     = mode_reg ? 2'd2 : 2'd1;
    assign job_inter = ({1'b0, job_k_reg} >= (KW'(job_o_reg) + KW'(m_sel)))
                       && (job_o_reg >= m_sel);
    assign job_end   = job_last_reg && (job_o_reg == 2'd0);

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= issue;
            end
            for (int s = 1; s < NSTG; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Center value, previous value and flags carried along every stage.
    fix_t            c_reg  [NSTG-1][2];
    fix_t            pd_reg [NSTG-1][2];
    logic [NSTG-2:0] inter_reg;
    logic [NSTG-2:0] end_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            c_reg[0][0]  <= nb[0][2];
            c_reg[0][1]  <= nb[1][2];
            pd_reg[0][0] <= pd_re_reg[job_o_reg];
            pd_reg[0][1] <= pd_im_reg[job_o_reg];
            inter_reg[0] <= job_inter;
            end_reg[0]   <= job_end;
        end
        for (int s = 1; s < NSTG - 1; s++)
        begin
            if (adv[s])
            begin
                c_reg[s]     <= c_reg[s-1];
                pd_reg[s]    <= pd_reg[s-1];
                inter_reg[s] <= inter_reg[s-1];
                end_reg[s]   <= end_reg[s-1];
            end
        end
    end

    // Stage 0: second and first differences of both widths.
    fix_t s0_d2_reg [2];
    fix_t s0_g_reg  [2];
    fix_t s0_fd2_reg [2];
    fix_t s0_gd_reg [2];
    fix_t s0_chi_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int p = 0; p < 2; p++)
            begin
                s0_d2_reg[p]  <= sat32(64'(nb[p][3]) - 64'(nb[p][2]) - 64'(nb[p][2])
                                       + 64'(nb[p][1]));
                s0_g_reg[p]   <= sat32(64'(nb[p][1]) - 64'(nb[p][3]));
                s0_fd2_reg[p] <= sat32(64'(nb[p][4]) - 64'(nb[p][2]) - 64'(nb[p][2])
                                       + 64'(nb[p][0]));
                s0_gd_reg[p]  <= sat32(64'(nb[p][0]) - 64'(nb[p][4]));
            end
            s0_chi_reg <= chi_reg[job_o_reg];
        end
    end

    // Stage 1: first products.
    fix_t s1_q_reg   [2];
    fix_t s1_fq_reg  [2];
    fix_t s1_dg_reg  [2];
    fix_t s1_g2a_reg [2];
    fix_t s1_g_reg   [2];
    fix_t s1_chp_reg [2];
    fix_t s1_pp_reg  [2];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int p = 0; p < 2; p++)
            begin
                s1_q_reg[p]   <= mq(s0_d2_reg[p], idx2_reg);
                s1_fq_reg[p]  <= mq(s0_fd2_reg[p], idx2_reg);
                s1_dg_reg[p]  <= mq(delta_reg, s0_g_reg[p]);
                s1_g2a_reg[p] <= mq(delta_reg, s0_gd_reg[p]);
                s1_g_reg[p]   <= s0_g_reg[p];
                s1_chp_reg[p] <= mq(s0_chi_reg, c_reg[0][p]);
            end
            s1_pp_reg[0] <= mq(pcoef_reg, pd_reg[0][1]);
            s1_pp_reg[1] <= mq(pcoef_reg, pd_reg[0][0]);
        end
    end

    // Stage 2: delta products of the laplacian; reduced gradient complete.
    fix_t s2_q_reg   [2];
    fix_t s2_dq_reg  [2];
    fix_t s2_f2a_reg [2];
    fix_t s2_gf_reg  [2];
    fix_t s2_chp_reg [2];
    fix_t s2_pp_reg  [2];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int p = 0; p < 2; p++)
            begin
                s2_q_reg[p]   <= s1_q_reg[p];
                s2_dq_reg[p]  <= mq(delta_reg, s1_q_reg[p]);
                s2_f2a_reg[p] <= mq(delta_reg, s1_fq_reg[p]);
                if (mode_reg)
                begin
                    // A product by one half is a rounded shift by one.
                    s2_gf_reg[p] <= sat32(64'(s1_g_reg[p]) + 64'(s1_dg_reg[p])
                                          - 64'((33'(s1_g2a_reg[p]) + 33'sd1) >>> 1));
                end
                else
                begin
                    s2_gf_reg[p] <= s1_g_reg[p];
                end
                s2_chp_reg[p] <= s1_chp_reg[p];
                s2_pp_reg[p]  <= s1_pp_reg[p];
            end
        end
    end

    // Stage 3: laplacian complete; advection products.
    fix_t s3_qf_reg  [2];
    fix_t s3_ag_reg  [2];
    fix_t s3_chp_reg [2];
    fix_t s3_pp_reg  [2];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int p = 0; p < 2; p++)
            begin
                if (mode_reg)
                begin
                    // A product by one quarter is a rounded shift by two.
                    s3_qf_reg[p] <= sat32(64'(s2_q_reg[p]) + 64'(s2_dq_reg[p])
                                          - 64'((34'(s2_f2a_reg[p]) + 34'sd2) >>> 2));
                end
                else
                begin
                    s3_qf_reg[p] <= s2_q_reg[p];
                end
                s3_chp_reg[p] <= s2_chp_reg[p];
                s3_pp_reg[p]  <= s2_pp_reg[p];
            end
            s3_ag_reg[0] <= mq(adv_coef_reg, s2_gf_reg[1]);
            s3_ag_reg[1] <= mq(adv_coef_reg, s2_gf_reg[0]);
        end
    end

    // Stage 4: operator sum and the exact previous-value part.
    fix_t                s4_t_reg  [2];
    logic signed [35:0]  s4_vb_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_t_reg[0]  <= sat32(64'(s3_qf_reg[0]) - 64'(s3_ag_reg[0]) - 64'(s3_chp_reg[0]));
            s4_t_reg[1]  <= sat32(64'(s3_qf_reg[1]) + 64'(s3_ag_reg[1]) - 64'(s3_chp_reg[1]));
            s4_vb_reg[0] <= 36'(c_reg[3][0]) + 36'(c_reg[3][0]) - 36'(pd_reg[3][0])
                            + 36'(s3_pp_reg[0]);
            s4_vb_reg[1] <= 36'(c_reg[3][1]) + 36'(c_reg[3][1]) - 36'(pd_reg[3][1])
                            - 36'(s3_pp_reg[1]);
        end
    end

    // Stage 5: time-step product.
    fix_t               s5_u_reg  [2];
    logic signed [35:0] s5_vb_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int p = 0; p < 2; p++)
            begin
                s5_u_reg[p]  <= mq(s4_t_reg[p], dt2_reg);
                s5_vb_reg[p] <= s4_vb_reg[p];
            end
        end
    end

    // Stage 6: unscaled new value.
    fix_t s6_v_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int p = 0; p < 2; p++)
            begin
                s6_v_reg[p] <= sat32(64'(s5_u_reg[p]) + 64'(s5_vb_reg[p]));
            end
        end
    end

    // Stage 7: complex scale products.
    fix_t s7_rr_reg;
    fix_t s7_ii_reg;
    fix_t s7_ri_reg;
    fix_t s7_ir_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_rr_reg <= mq(sr_reg, s6_v_reg[0]);
            s7_ii_reg <= mq(si_reg, s6_v_reg[1]);
            s7_ri_reg <= mq(sr_reg, s6_v_reg[1]);
            s7_ir_reg <= mq(si_reg, s6_v_reg[0]);
        end
    end

    // Stage 8: output register; boundary cells pass through.
    fix_t out_nr_reg;
    fix_t out_ni_reg;
    fix_t out_sr_reg;
    fix_t out_si_reg;
    logic out_end_reg;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            if (inter_reg[7])
            begin
                out_nr_reg <= sat32(64'(s7_rr_reg) - 64'(s7_ii_reg));
                out_ni_reg <= sat32(64'(s7_ri_reg) + 64'(s7_ir_reg));
                out_sr_reg <= c_reg[7][0];
                out_si_reg <= c_reg[7][1];
            end
            else
            begin
                out_nr_reg <= c_reg[7][0];
                out_ni_reg <= c_reg[7][1];
                out_sr_reg <= pd_reg[7][0];
                out_si_reg <= pd_reg[7][1];
            end
            out_end_reg <= end_reg[7];
        end
    end

    assign result_out.valid         = v_reg[NSTG-1];
    assign result_out.next_re       = out_nr_reg;
    assign result_out.next_im       = out_ni_reg;
    assign result_out.store_prev_re = out_sr_reg;
    assign result_out.store_prev_im = out_si_reg;
    assign result_out.row_end       = out_end_reg;

endmodule

// ===== hdl/cesu_checker.sv =====
// Port-level checks for the envelope stencil core, attached by a bind.
// Depends on cesu_pkg and complex_envelope_stencil_update_core.
module cesu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input cesu_pkg::fix_t      out_next_re,
    input logic                out_row_end
);
    import cesu_pkg::*;

    // A stalled result keeps its value and its row marker.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_next_re)
                                        && $stable(out_row_end)))
        else $error("stalled result changed");

    // While reset is held, no result is offered.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // Right after reset the sequencer is empty, so a cell can be taken.
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

endmodule

bind complex_envelope_stencil_update_core cesu_checker u_cesu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (cell_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_next_re (result_out.next_re),
    .out_row_end (result_out.row_end)
);
